// File: sv/batch_norm_inference_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the batch normalization block.
// They expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef BATCH_NORM_INFERENCE_MACROS_SVH
`define BATCH_NORM_INFERENCE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BN_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/bn_pkg.sv
// ----------------------------------------------------------------------------
// bn_pkg
// Shared types, constants and helpers of the batch normalization block.
// ----------------------------------------------------------------------------
`default_nettype none

package bn_pkg;

	localparam int unsigned MAX_CHANNELS_DEF = 1024;
	localparam int unsigned SQRT_STEPS       = 24;
	localparam int unsigned DIV_STEPS        = 48;
	localparam int unsigned CNT_W            = 6;

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	typedef enum logic [1:0] {
		CFG_PLANE_SIZE    = 2'd0,
		CFG_CHANNEL_COUNT = 2'd1,
		CFG_EPSILON       = 2'd2
	} bn_cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD_SQRT,
		S_LOAD_PREP,
		S_LOAD_DIV,
		S_LOAD_GAIN,
		S_LOAD_MUL,
		S_LOAD_WR,
		S_SAMP_RD,
		S_SAMP_MUL,
		S_SAMP_ADD
	} bn_state_t;

	typedef struct packed {
		logic capture;
		logic sqrt_step;
		logic div_init;
		logic div_step;
		logic gain_set;
		logic mul_en;
		logic wr_en;
		logic rd_en;
		logic pos_advance;
		logic out_load;
	} bn_cmd_t;

	// Saturate a 49-bit signed sum to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
		logic signed [48:0] hi;
		logic signed [48:0] lo;
		hi = 49'(Q_MAX);
		lo = 49'(Q_MIN);
		if (v > hi)
			return Q_MAX;
		else if (v < lo)
			return Q_MIN;
		else
			return v[31:0];
	endfunction

endpackage

`default_nettype wire

// File: sv/bn_if.sv
// ----------------------------------------------------------------------------
// Stream interfaces
// Input and result channels of the batch normalization block.
// ----------------------------------------------------------------------------
`default_nettype none

interface bn_in_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [9:0]         channel_slot;
	logic signed [31:0] mean_value;
	logic [30:0]        variance_value;
	logic signed [31:0] scale_value;
	logic signed [31:0] bias_value;
	logic signed [31:0] sample_value;
	logic               last_sample;

	modport source (output valid, kind, channel_slot, mean_value, variance_value,
		scale_value, bias_value, sample_value, last_sample, input ready);
	modport sink (input valid, kind, channel_slot, mean_value, variance_value,
		scale_value, bias_value, sample_value, last_sample, output ready);
endinterface

interface bn_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_value;
	logic               result_last;

	modport source (output valid, result_value, result_last, input ready);
	modport sink (input valid, result_value, result_last, output ready);
endinterface

`default_nettype wire

// File: sv/bn_ram.sv
// ----------------------------------------------------------------------------
// bn_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bn_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: sv/bn_ctrl.sv
// ----------------------------------------------------------------------------
// bn_ctrl
// Sequencer: steps loads through root, divide and multiply, and samples
// through read, multiply and add; owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "batch_norm_inference_macros.svh"

module bn_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            in_kind,
	output      logic            in_ready,
	input  wire logic            out_ready,
	output      logic            out_valid,
	output      bn_pkg::bn_cmd_t cmd
);

	import bn_pkg::*;

	bn_state_t        state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_d = (in_kind == KIND_SAMPLE) ? S_SAMP_RD : S_LOAD_SQRT;
			end
			S_LOAD_SQRT: begin
				if (cnt_q == CNT_W'(SQRT_STEPS - 1))
					state_d = S_LOAD_PREP;
			end
			S_LOAD_PREP: state_d = S_LOAD_DIV;
			S_LOAD_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1))
					state_d = S_LOAD_GAIN;
			end
			S_LOAD_GAIN: state_d = S_LOAD_MUL;
			S_LOAD_MUL:  state_d = S_LOAD_WR;
			S_LOAD_WR:   state_d = S_IDLE;
			S_SAMP_RD:   state_d = S_SAMP_MUL;
			S_SAMP_MUL:  state_d = S_SAMP_ADD;
			S_SAMP_ADD: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd             = '0;
		in_ready        = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_LOAD_SQRT: cmd.sqrt_step = 1'b1;
			S_LOAD_PREP: cmd.div_init  = 1'b1;
			S_LOAD_DIV:  cmd.div_step  = 1'b1;
			S_LOAD_GAIN: cmd.gain_set  = 1'b1;
			S_LOAD_MUL:  cmd.mul_en    = 1'b1;
			S_LOAD_WR:   cmd.wr_en     = 1'b1;
			S_SAMP_RD: begin
				cmd.rd_en       = 1'b1;
				cmd.pos_advance = 1'b1;
			end
			S_SAMP_MUL: cmd.mul_en   = 1'b1;
			S_SAMP_ADD: cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q)
				cnt_q <= '0;
			else
				cnt_q <= cnt_q + 1'b1;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`BN_ASSERT_NEXT(a_sample_reads, in_valid && state_q == S_IDLE && in_kind == KIND_SAMPLE, state_q == S_SAMP_RD, "sample did not start with a read")
	`BN_ASSERT_NOW(a_div_count, $rose(state_q == S_LOAD_DIV), cnt_q == '0, "divide entered with stale count")
	`BN_ASSERT_NOW(a_result_src, $rose(out_valid_q), $past(state_q) == S_SAMP_ADD, "result raised outside the add step")

endmodule

`default_nettype wire

// File: sv/bn_datapath.sv
// ----------------------------------------------------------------------------
// bn_datapath
// Configuration, root and divide units, shared multiplier, parameter RAMs
// and position counters.
// ----------------------------------------------------------------------------
`default_nettype none

module bn_datapath #(
	parameter int unsigned MAX_CHANNELS = bn_pkg::MAX_CHANNELS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bn_pkg::bn_cmd_t    cmd,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [16:0]        cfg_wdata,
	input  wire logic               kind,
	input  wire logic [9:0]         channel_slot,
	input  wire logic signed [31:0] mean_value,
	input  wire logic [30:0]        variance_value,
	input  wire logic signed [31:0] scale_value,
	input  wire logic signed [31:0] bias_value,
	input  wire logic signed [31:0] sample_value,
	input  wire logic               last_sample,
	output      logic signed [31:0] result_value,
	output      logic               result_last
);

	import bn_pkg::*;

	localparam int unsigned AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam logic [16:0] MAXC = 17'(MAX_CHANNELS);

	logic [16:0] plane_size_q;
	logic [10:0] channel_count_q;
	logic [15:0] epsilon_q;
	logic [15:0] plane_pos_q;
	logic [9:0]  chan_pos_q;

	logic               kind_q, last_q;
	logic [9:0]         slot_q;
	logic signed [31:0] mean_q, scale_q, bias_q, x_q;

	logic [47:0] rad_q;
	logic [25:0] srem_q;
	logic [23:0] root_q;
	logic [47:0] dvd_q;
	logic [24:0] drem_q;
	logic signed [31:0] gain_q;
	logic signed [63:0] prod_q;

	logic signed [31:0] gain_rd, off_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_size_q    <= 17'd1;
			channel_count_q <= 11'd1;
			epsilon_q       <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PLANE_SIZE:    plane_size_q    <= cfg_wdata;
				CFG_CHANNEL_COUNT: channel_count_q <= cfg_wdata[10:0];
				CFG_EPSILON:       epsilon_q       <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// Root step: brings two radicand bits into the partial remainder.
	logic [27:0] sq_rem, sq_trial;
	assign sq_rem   = {srem_q, rad_q[47:46]};
	assign sq_trial = {2'b00, root_q, 2'b01};

	// Restoring divide step.
	logic [25:0] dv_rem;
	assign dv_rem = {drem_q, dvd_q[47]};

	logic [31:0] scale_mag;
	assign scale_mag = scale_q[31] ? 32'(-scale_q) : scale_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kind;
			slot_q  <= channel_slot;
			mean_q  <= mean_value;
			scale_q <= scale_value;
			bias_q  <= bias_value;
			x_q     <= sample_value;
			last_q  <= last_sample;
			rad_q   <= {32'(variance_value) + 32'(epsilon_q), 16'h0000};
			srem_q  <= '0;
			root_q  <= '0;
		end
		if (cmd.sqrt_step) begin
			rad_q <= {rad_q[45:0], 2'b00};
			if (sq_rem >= sq_trial) begin
				srem_q <= 26'(sq_rem - sq_trial);
				root_q <= {root_q[22:0], 1'b1};
			end else begin
				srem_q <= sq_rem[25:0];
				root_q <= {root_q[22:0], 1'b0};
			end
		end
		if (cmd.div_init) begin
			dvd_q  <= {scale_mag, 16'h0000};
			drem_q <= '0;
		end
		if (cmd.div_step) begin
			if (dv_rem >= 26'(root_q)) begin
				drem_q <= 25'(dv_rem - 26'(root_q));
				dvd_q  <= {dvd_q[46:0], 1'b1};
			end else begin
				drem_q <= dv_rem[24:0];
				dvd_q  <= {dvd_q[46:0], 1'b0};
			end
		end
		if (cmd.gain_set) begin
			if (root_q == '0)
				gain_q <= scale_q[31] ? Q_MIN : ((scale_q == '0) ? 32'sd0 : Q_MAX);
			else if (!scale_q[31])
				gain_q <= (dvd_q > 48'(Q_MAX)) ? Q_MAX : dvd_q[31:0];
			else
				gain_q <= (dvd_q > 48'h0000_8000_0000) ? Q_MIN : 32'(-dvd_q);
		end
		if (cmd.mul_en) begin
			if (kind_q == KIND_SAMPLE)
				prod_q <= gain_rd * x_q;
			else
				prod_q <= gain_q * mean_q;
		end
	end

	// Arithmetic shift gives the floor of the product over 65536.
	logic signed [47:0] p16;
	logic signed [48:0] sum;
	logic signed [31:0] sum_sat;
	assign p16     = prod_q[63:16];
	assign sum     = (kind_q == KIND_SAMPLE) ? (49'(p16) + 49'(off_rd))
		: (49'(bias_q) - 49'(p16));
	assign sum_sat = sat32(sum);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_value <= sum_sat;
			result_last  <= last_q;
		end
	end

	// Parameter RAMs.
	logic [16:0]   slot_ext, chan_ext, rd_ch;
	logic          slot_ok;
	assign slot_ext = 17'(slot_q);
	assign chan_ext = 17'(chan_pos_q);
	assign slot_ok  = slot_ext < MAXC;
	assign rd_ch    = (chan_ext < MAXC) ? chan_ext : 17'd0;

	bn_ram #(.WIDTH(32), .DEPTH(MAX_CHANNELS)) u_gain_ram (
		.clk(clk), .we(cmd.wr_en && slot_ok), .waddr(slot_ext[AW-1:0]),
		.wdata(gain_q), .re(cmd.rd_en), .raddr(rd_ch[AW-1:0]), .rdata(gain_rd)
	);

	bn_ram #(.WIDTH(32), .DEPTH(MAX_CHANNELS)) u_offset_ram (
		.clk(clk), .we(cmd.wr_en && slot_ok), .waddr(slot_ext[AW-1:0]),
		.wdata(sum_sat), .re(cmd.rd_en), .raddr(rd_ch[AW-1:0]), .rdata(off_rd)
	);

	// Position counters with clamped bounds.
	logic [16:0] psize_eff, ccount_eff, np, nc;
	always_comb begin
		psize_eff = plane_size_q;
		if (psize_eff == '0)
			psize_eff = 17'd1;
		else if (psize_eff > 17'd65536)
			psize_eff = 17'd65536;
		ccount_eff = 17'(channel_count_q);
		if (ccount_eff == '0)
			ccount_eff = 17'd1;
		else if (ccount_eff > MAXC)
			ccount_eff = MAXC;
		np = 17'(plane_pos_q) + 17'd1;
		nc = chan_ext + 17'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_pos_q <= '0;
			chan_pos_q  <= '0;
		end else if (cmd.pos_advance) begin
			if (last_q) begin
				plane_pos_q <= '0;
				chan_pos_q  <= '0;
			end else if (np >= psize_eff) begin
				plane_pos_q <= '0;
				chan_pos_q  <= (nc >= ccount_eff) ? 10'd0 : nc[9:0];
			end else begin
				plane_pos_q <= np[15:0];
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/batch_norm_inference.sv
// ----------------------------------------------------------------------------
// batch_norm_inference
// Per-channel batch normalization of a Q16.16 element stream.
//
//  channel  | dir | moves
//  ---------+-----+------------------------------------------------
//  in_ch    | in  | one item: a parameter load or one data sample
//  out_ch   | out | one normalized result per sample item
//  cfg_*    | in  | register writes: plane size, channels, epsilon
//
// A sample item passes through the parameter RAM read, the 32x32
// multiply and the saturating add into the output register.
// A load item runs the 24-step bit-serial square root and the 48-step
// restoring divide, followed by multiply and write.
// Reset clears the sequencer and positions and sets the configuration
// registers to 1; the parameter RAMs hold nothing defined until a load
// writes them. A stalled result waits in the output register while the
// next item is taken; a sample finishes only once that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module batch_norm_inference #(
	parameter int unsigned MAX_CHANNELS = bn_pkg::MAX_CHANNELS_DEF
) (
	input wire logic        clk,
	input wire logic        arst_n,
	bn_in_if.sink           in_ch,
	bn_out_if.source        out_ch,
	input wire logic        cfg_we,
	input wire logic [1:0]  cfg_index,
	input wire logic [16:0] cfg_wdata
);

	import bn_pkg::*;

	// Command word from the sequencer to the datapath.
	bn_cmd_t cmd;

	// The sequencer decides when items move and which unit works.
	bn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_kind  (in_ch.kind),
		.in_ready (in_ch.ready),
		.out_ready(out_ch.ready),
		.out_valid(out_ch.valid),
		.cmd      (cmd)
	);

	// The datapath holds all arithmetic, storage and counters.
	bn_datapath #(.MAX_CHANNELS(MAX_CHANNELS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.kind          (in_ch.kind),
		.channel_slot  (in_ch.channel_slot),
		.mean_value    (in_ch.mean_value),
		.variance_value(in_ch.variance_value),
		.scale_value   (in_ch.scale_value),
		.bias_value    (in_ch.bias_value),
		.sample_value  (in_ch.sample_value),
		.last_sample   (in_ch.last_sample),
		.result_value  (out_ch.result_value),
		.result_last   (out_ch.result_last)
	);

endmodule

`default_nettype wire

// File: dv/tb_batch_norm_inference.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_batch_norm_inference
// Self-checking testbench for the per-channel batch normalization block.
// A table of directed items runs first. Random parameter loads and sample
// streams follow under several register settings. Results are compared with
// typed row values or a predictor with its own gain/offset tables and positions.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_batch_norm_inference;
	import bn_pkg::*;

	localparam int  CHANNELS    = 1024;
	localparam int  SETTLE      = 120;       // covers a load still in the divide
	localparam int  CYCLE_LIMIT = 1_500_000;
	localparam int  LONG_HOLD   = 300;
	localparam int  PHASE_ITEMS = 190;

	typedef struct {
		logic               kind;
		logic [9:0]         slot;
		logic signed [31:0] mean;
		logic [30:0]        variance;
		logic signed [31:0] scale;
		logic signed [31:0] bias;
		logic signed [31:0] x;
		logic               last;
		bit                 typed;    // expected value given in the row
		logic signed [31:0] typed_val;
	} item_t;

	typedef struct {
		logic signed [31:0] value;
		logic               last;
	} norm_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [16:0] cfg_wdata = '0;

	bn_in_if  in_bus();
	bn_out_if out_bus();

	batch_norm_inference uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_bus),
		.out_ch    (out_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// Predictor state: its own copy of the parameter tables, positions and registers.
	logic signed [31:0] gain_tab [CHANNELS];
	logic signed [31:0] offset_tab [CHANNELS];
	bit                 loaded [CHANNELS];
	int unsigned        plane_pos, chan_pos;
	int unsigned        plane_reg, count_reg, eps_reg;

	norm_t pending_norm [$];
	int    mismatches = 0;
	int    results_seen = 0;
	int    loads_sent = 0, samples_sent = 0;
	int    cycles = 0;
	bit    no_idle = 0;          // when set, neither side inserts random gaps
	bit    long_hold_done = 0;

	function automatic longint sat_q(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Bit-by-bit integer square root, floor result.
	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Derives gain and offset from one load item and stores them.
	function automatic void store_channel(item_t it);
		longint unsigned rt;
		longint g, m, s;
		rt = root_floor((longint'(it.variance) + longint'(eps_reg)) << 16);
		s = it.scale;
		m = it.mean;
		if (rt == 0)
			g = (s > 0) ? 64'sd2147483647 : ((s < 0) ? -64'sd2147483648 : 0);
		else
			g = sat_q((s * 65536) / longint'(rt));
		gain_tab[it.slot] = g[31:0];
		// Arithmetic shift gives the floor of the Q16.16 product.
		offset_tab[it.slot] = 32'(sat_q(longint'(it.bias) - ((g * m) >>> 16)));
		loaded[it.slot] = 1;
	endfunction

	// Normalizes one sample and moves the element position.
	function automatic norm_t normalize(item_t it);
		norm_t r;
		int unsigned ps, cc;
		longint g;
		ps = (plane_reg == 0) ? 1 : ((plane_reg > 65536) ? 65536 : plane_reg);
		cc = (count_reg == 0) ? 1 : ((count_reg > CHANNELS) ? CHANNELS : count_reg);
		g = gain_tab[chan_pos];
		r.value = 32'(sat_q(((g * longint'(it.x)) >>> 16)
			+ longint'(offset_tab[chan_pos])));
		r.last = it.last;
		if (it.last) begin
			plane_pos = 0;
			chan_pos = 0;
		end else if (plane_pos + 1 >= ps) begin
			plane_pos = 0;
			chan_pos = (chan_pos + 1 >= cc) ? 0 : ((chan_pos + 1) & 10'h3FF);
		end else begin
			plane_pos = plane_pos + 1;
		end
		return r;
	endfunction

	// Random Q16.16 value that favors extremes and a spread of magnitudes.
	function automatic logic signed [31:0] rand_q();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return $signed($urandom()) >>> $urandom_range(1, 28);
			3: return $signed($urandom_range(0, 8)) * 32'sd16384 - 32'sd65536;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [30:0] rand_var();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return 31'h7FFF_FFFF;
			2: return 31'($urandom_range(0, 31'h4_0000));
			default: return 31'($urandom() >> $urandom_range(1, 24));
		endcase
	endfunction

	task automatic write_reg(bn_cfg_idx_t idx, int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[16:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_PLANE_SIZE:    plane_reg = val;
			CFG_CHANNEL_COUNT: count_reg = val;
			default:           eps_reg = val;
		endcase
		@(posedge clk);
	endtask

	// Offers one item, waits for acceptance and records the expectation.
	// Valid is left high; a gap in the next call, or quiesce, lowers it.
	task automatic offer(item_t it);
		int gap;
		norm_t r;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_bus.valid <= 1'b1;
		in_bus.kind <= it.kind;
		in_bus.channel_slot <= it.slot;
		in_bus.mean_value <= it.mean;
		in_bus.variance_value <= it.variance;
		in_bus.scale_value <= it.scale;
		in_bus.bias_value <= it.bias;
		in_bus.sample_value <= it.x;
		in_bus.last_sample <= it.last;
		do @(posedge clk); while (!in_bus.ready);
		if (it.kind == KIND_LOAD) begin
			store_channel(it);
			loads_sent++;
		end else begin
			r = normalize(it);
			if (it.typed) r.value = it.typed_val;
			pending_norm.push_back(r);
			samples_sent++;
		end
	endtask

	// Drops valid, waits for every expected result, then lets a load finish.
	task automatic quiesce();
		in_bus.valid <= 1'b0;
		while (pending_norm.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic item_t mk_load(int unsigned slot, logic signed [31:0] mean,
			logic [30:0] variance, logic signed [31:0] scale, logic signed [31:0] bias);
		item_t it;
		it = '{KIND_LOAD, slot[9:0], mean, variance, scale, bias, rand_q(),
			1'($urandom_range(0, 1)), 0, 0};
		return it;
	endfunction

	function automatic item_t mk_sample(logic signed [31:0] x, logic last,
			bit typed, logic signed [31:0] val);
		item_t it;
		it = '{KIND_SAMPLE, 10'($urandom()), rand_q(), rand_var(), rand_q(), rand_q(),
			x, last, typed, val};
		return it;
	endfunction

	// Result side: checks every accepted result and draws its own stalls,
	// including one long hold-off that lets the block back up its input.
	always @(posedge clk or negedge arst_n) begin
		int hold;
		int next_hold;
		norm_t e;
		if (!arst_n) begin
			out_bus.ready <= 1'b0;
			hold = 0;
		end else begin
			next_hold = hold;
			if (out_bus.valid && out_bus.ready) begin
				results_seen++;
				if (pending_norm.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %h last %b",
							out_bus.result_value, out_bus.result_last);
				end else begin
					e = pending_norm.pop_front();
					if (e.value !== out_bus.result_value || e.last !== out_bus.result_last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: expected %h/%b, got %h/%b", results_seen,
								e.value, e.last, out_bus.result_value, out_bus.result_last);
					end
				end
				if (results_seen == 250 && !long_hold_done) begin
					next_hold = LONG_HOLD;
					long_hold_done = 1;
				end else begin
					next_hold = no_idle ? 0 : $urandom_range(0, 3);
				end
			end
			if (next_hold > 0) begin
				out_bus.ready <= 1'b0;
				hold = next_hold - 1;
			end else begin
				out_bus.ready <= 1'b1;
				hold = 0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Directed table. Register setting: plane size 1, four channels, epsilon 0,
	// so a variance of 1.0 gives a gain equal to the scale, and a zero variance
	// gives a zero root. Rows with a typed value are read straight off that.
	item_t dir_tab [$];

	// Random register settings, extremes among them.
	int unsigned ph_plane [6] = '{1, 3, 2, 65536, 1, 5};
	int unsigned ph_count [6] = '{1, 5, 1024, 2, 4, 3};
	int unsigned ph_eps   [6] = '{1, 0, 65535, 7, 100, 1};

	initial begin
		in_bus.valid = 1'b0;
		in_bus.kind = KIND_LOAD;
		in_bus.channel_slot = '0;
		in_bus.mean_value = '0;
		in_bus.variance_value = '0;
		in_bus.scale_value = '0;
		in_bus.bias_value = '0;
		in_bus.sample_value = '0;
		in_bus.last_sample = 1'b0;
		plane_pos = 0;
		chan_pos = 0;
		plane_reg = 1;
		count_reg = 1;
		eps_reg = 1;
		foreach (loaded[i]) loaded[i] = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(CFG_PLANE_SIZE, 1);
		write_reg(CFG_CHANNEL_COUNT, 4);
		write_reg(CFG_EPSILON, 0);

		// Channel 0 passes x through, 1 and 2 hit the zero root with a positive
		// and a negative scale, 3 has a zero scale so only the bias remains.
		dir_tab.push_back(mk_load(0, 0, 31'h1_0000, 32'sh1_0000, 0));
		dir_tab.push_back(mk_load(1, 0, 0, 32'sh1_0000, 0));
		dir_tab.push_back(mk_load(2, 0, 0, -32'sh1_0000, 0));
		dir_tab.push_back(mk_load(3, 0, 0, 0, 5));
		dir_tab.push_back(mk_sample(32'sh7FFF_FFFF, 0, 1, 32'sh7FFF_FFFF));
		dir_tab.push_back(mk_sample(32'sh1_0000, 0, 1, 32'sh7FFF_FFFF));
		dir_tab.push_back(mk_sample(32'sh1_0000, 0, 1, 32'sh8000_0000));
		dir_tab.push_back(mk_sample(32'sd123, 0, 1, 5));
		dir_tab.push_back(mk_sample(32'sh8000_0000, 0, 1, 32'sh8000_0000));
		dir_tab.push_back(mk_sample(-32'sh1_0000, 0, 1, 32'sh8000_0001));
		dir_tab.push_back(mk_sample(-32'sh1_0000, 0, 1, 32'sh7FFF_FFFF));
		// A last flag mid-tensor sends the position back to channel 0.
		dir_tab.push_back(mk_sample(0, 1, 1, 5));
		dir_tab.push_back(mk_sample(32'sh7FFF_FFFF, 0, 1, 32'sh7FFF_FFFF));
		// Extreme parameters go through the predictor from here on.
		dir_tab.push_back(mk_load(1, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh8000_0000,
			32'sh7FFF_FFFF));
		dir_tab.push_back(mk_load(2, 32'sh8000_0000, 31'h1, 32'sh7FFF_FFFF,
			32'sh8000_0000));
		dir_tab.push_back(mk_load(3, 32'sh8000_0000, 0, -32'sd1, 32'sh8000_0000));
		dir_tab.push_back(mk_load(1023, 32'sh1234_5678, 31'h5555_5555, 32'sh7FFF_FFFF,
			-32'sd1));
		dir_tab.push_back(mk_sample(32'sh8000_0000, 0, 0, 0));
		dir_tab.push_back(mk_sample(32'sh7FFF_FFFF, 0, 0, 0));
		dir_tab.push_back(mk_sample(32'sh8000_0000, 0, 0, 0));
		dir_tab.push_back(mk_sample(-32'sd1, 1, 0, 0));
		foreach (dir_tab[i]) offer(dir_tab[i]);
		quiesce();

		// Random phases: lazy loads keep every channel that a sample reaches written,
		// other loads hit slots 0 to channel count + 3, and last flags cut tensors.
		for (int p = 0; p < 6; p++) begin
			write_reg(CFG_PLANE_SIZE, ph_plane[p]);
			write_reg(CFG_CHANNEL_COUNT, ph_count[p]);
			write_reg(CFG_EPSILON, ph_eps[p]);
			no_idle = (p == 4);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 1 && n == PHASE_ITEMS / 2) quiesce();
				if (!loaded[chan_pos]) begin
					offer(mk_load(chan_pos, rand_q(), rand_var(), rand_q(), rand_q()));
				end else if ($urandom_range(0, 9) == 0) begin
					offer(mk_load($urandom_range(0, ph_count[p] + 3) % CHANNELS,
						rand_q(), rand_var(), rand_q(), rand_q()));
				end else begin
					offer(mk_sample(rand_q(), $urandom_range(0, 24) == 0, 0, 0));
				end
			end
			quiesce();
		end

		if (pending_norm.size() != 0) mismatches += pending_norm.size();
		$display("covered %0d loads and %0d samples over 7 register settings,",
			loads_sent, samples_sent);
		$display("%0d results checked, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
